### rtl/core/bscfd_pkg.sv
// ----------------------------------------------------------------------------
// bscfd_pkg
// Shared types, constants and the byte-wide crc-32 update for the deframer.
// ----------------------------------------------------------------------------
package bscfd_pkg;

  localparam int unsigned MaxRawFrame = 128;
  localparam int unsigned TailLen     = 4;
  localparam int unsigned CmdDepth    = 4;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_BYTE  = 3'd0,
    REG_END_BYTE    = 3'd1,
    REG_ESCAPE_BYTE = 3'd2,
    REG_ESC_START   = 3'd3,
    REG_ESC_END     = 3'd4,
    REG_ESC_ESCAPE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [7:0] esc_start_code;
    logic [7:0] esc_end_code;
    logic [7:0] esc_escape_code;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_e;

  // flag: close-at-once for start, too-long for end
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       flag;
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CRC_ERR   = 2'd1,
    STAT_TOO_LONG  = 2'd2,
    STAT_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic {
    ST_HUNT  = 1'b0,
    ST_FRAME = 1'b1
  } front_state_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/byte_stuffed_crc_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// byte_stuffed_crc_frame_decoder_top
// Byte-stuffed frame deframer with trailing big-endian crc-32 check.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata[7:0] rx_byte
//   m_axis    out  m_axis_tvalid/tready      tdata payload_byte, frame_status;
//                                            tuser is_frame_end
//   cfg       in   cfg_we                    cfg_idx, cfg_wdata
//
// One input beat per cycle; a result is loaded into the output register as
// its command leaves the queue. The four-entry command queue lets the front
// keep taking beats while the output is stalled, and s_axis_tready drops
// only when that queue is full. Reset clears the frame state and loads the
// default framing bytes; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_stuffed_crc_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [9:8] frame_status
  output logic        m_axis_tuser_o,   // [0] is_frame_end
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import bscfd_pkg::*;

  cfg_t cfg_q;
  logic fifo_full, accept, f_cmd_valid, q_valid, pop;
  cmd_t f_cmd, q_head;
  logic [7:0] out_pay;
  logic [1:0] out_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= 8'd170;
      cfg_q.end_byte        <= 8'd85;
      cfg_q.escape_byte     <= 8'd204;
      cfg_q.esc_start_code  <= 8'd1;
      cfg_q.esc_end_code    <= 8'd2;
      cfg_q.esc_escape_code <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_BYTE:  cfg_q.start_byte      <= cfg_wdata_i;
        REG_END_BYTE:    cfg_q.end_byte        <= cfg_wdata_i;
        REG_ESCAPE_BYTE: cfg_q.escape_byte     <= cfg_wdata_i;
        REG_ESC_START:   cfg_q.esc_start_code  <= cfg_wdata_i;
        REG_ESC_END:     cfg_q.esc_end_code    <= cfg_wdata_i;
        REG_ESC_ESCAPE:  cfg_q.esc_escape_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !fifo_full;
  assign accept          = s_axis_tvalid_i && !fifo_full;

  bscfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .cmd_valid_o (f_cmd_valid),
    .cmd_o       (f_cmd)
  );

  bscfd_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_cmd_valid),
    .push_cmd_i (f_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  bscfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_is_end_o  (m_axis_tuser_o),
    .out_payload_o (out_pay),
    .out_status_o  (out_stat)
  );

  assign m_axis_tdata_o = {6'd0, out_stat, out_pay};

endmodule

### rtl/core/bscfd_front.sv
// ----------------------------------------------------------------------------
// bscfd_front
// Start hunt, escape removal and raw length count; issues one command per
// byte that matters to the back end.
// ----------------------------------------------------------------------------
module bscfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bscfd_pkg::cfg_t   cfg_i,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output logic              cmd_valid_o,
  output bscfd_pkg::cmd_t   cmd_o
);
  import bscfd_pkg::*;

  front_state_e state_q, state_d;
  logic         esc_q, esc_d;
  logic [7:0]   raw_q, raw_d;

  logic is_start, is_end, is_esc;

  assign is_start = (byte_i == cfg_i.start_byte);
  assign is_end   = (byte_i == cfg_i.end_byte);
  assign is_esc   = (byte_i == cfg_i.escape_byte);

  // next state
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      unique case (state_q)
        ST_HUNT: begin
          if (is_start && !is_end) state_d = ST_FRAME;
        end
        ST_FRAME: begin
          if (is_end) state_d = ST_HUNT;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // outputs and frame counters
  always_comb begin
    esc_d       = esc_q;
    raw_d       = raw_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_DATA;
    cmd_o.data  = byte_i;
    cmd_o.flag  = 1'b0;
    if (accept_i) begin
      unique case (state_q)
        ST_HUNT: begin
          if (is_start) begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_START;
            cmd_o.flag  = is_end;
            esc_d       = 1'b0;
            raw_d       = is_end ? 8'd0 : 8'd1;
          end
        end
        ST_FRAME: begin
          if (is_end) begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_END;
            cmd_o.data  = cfg_i.end_byte;
            cmd_o.flag  = (raw_q >= 8'(MaxRawFrame));
            esc_d       = 1'b0;
            raw_d       = 8'd0;
          end else begin
            if (raw_q != 8'hFF) raw_d = raw_q + 8'd1;
            esc_d = 1'b0;
            if (esc_q && byte_i == cfg_i.esc_start_code) begin
              cmd_valid_o = 1'b1;
              cmd_o.data  = cfg_i.start_byte;
            end else if (esc_q && byte_i == cfg_i.esc_end_code) begin
              cmd_valid_o = 1'b1;
              cmd_o.data  = cfg_i.end_byte;
            end else if (esc_q && byte_i == cfg_i.esc_escape_code) begin
              cmd_valid_o = 1'b1;
              cmd_o.data  = cfg_i.escape_byte;
            end else if (is_esc) begin
              // unknown code falls through here and may open a new escape
              esc_d = 1'b1;
            end else begin
              cmd_valid_o = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      esc_q   <= 1'b0;
      raw_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
      raw_q   <= raw_d;
    end
  end

endmodule

### rtl/core/bscfd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bscfd_cmd_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bscfd_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bscfd_pkg::cmd_t   push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bscfd_pkg::cmd_t   head_o
);
  import bscfd_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### rtl/core/bscfd_back.sv
// ----------------------------------------------------------------------------
// bscfd_back
// Four-byte tail delay, crc accumulation, frame check and output register.
// ----------------------------------------------------------------------------
module bscfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  bscfd_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_is_end_o,
  output logic [7:0]        out_payload_o,
  output logic [1:0]        out_status_o
);
  import bscfd_pkg::*;

  localparam int unsigned FillW = $clog2(TailLen + 1);
  localparam int unsigned IdxW  = $clog2(TailLen);

  logic [7:0]       tail_q [TailLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [31:0]      crc_q, crc_d;
  logic             vld_q;
  logic             is_end_q;
  logic [7:0]       pay_q;
  logic [1:0]       stat_q;

  logic        emit, emit_end, tail_full, shift_en, store_en;
  logic [7:0]  emit_pay;
  status_e     emit_stat;
  logic [31:0] crc_calc, crc_got;

  assign pop_o     = cmd_valid_i && (!vld_q || out_ready_i);
  assign tail_full = (fill_q == FillW'(TailLen));
  assign crc_calc  = ~crc_byte(crc_q, cmd_i.data);
  always_comb begin
    crc_got = '0;
    for (int i = 0; i < TailLen; i++) begin
      crc_got = {crc_got[23:0], tail_q[i]};
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_end  = 1'b0;
    emit_pay  = 8'd0;
    emit_stat = STAT_OK;
    fill_d    = fill_q;
    crc_d     = crc_q;
    shift_en  = 1'b0;
    store_en  = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_START: begin
          fill_d = '0;
          crc_d  = crc_byte(CrcInit, cmd_i.data);
          if (cmd_i.flag) begin
            // start byte doubles as end byte
            emit      = 1'b1;
            emit_end  = 1'b1;
            emit_stat = STAT_TOO_SHORT;
            crc_d     = CrcInit;
          end
        end
        CMD_DATA: begin
          if (tail_full) begin
            emit     = 1'b1;
            emit_pay = tail_q[0];
            crc_d    = crc_byte(crc_q, tail_q[0]);
            shift_en = 1'b1;
          end else begin
            store_en = 1'b1;
            fill_d   = fill_q + FillW'(1);
          end
        end
        CMD_END: begin
          emit     = 1'b1;
          emit_end = 1'b1;
          if (cmd_i.flag)             emit_stat = STAT_TOO_LONG;
          else if (!tail_full)        emit_stat = STAT_TOO_SHORT;
          else if (crc_calc != crc_got) emit_stat = STAT_CRC_ERR;
          else                        emit_stat = STAT_OK;
          fill_d = '0;
          crc_d  = CrcInit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < TailLen - 1; i++) begin
        tail_q[i] <= tail_q[i+1];
      end
      tail_q[TailLen-1] <= cmd_i.data;
    end else if (store_en) begin
      tail_q[fill_q[IdxW-1:0]] <= cmd_i.data;
    end
    if (emit) begin
      is_end_q <= emit_end;
      pay_q    <= emit_pay;
      stat_q   <= emit_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      crc_q  <= CrcInit;
      vld_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      crc_q  <= crc_d;
      if (emit)             vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_is_end_o  = is_end_q;
  assign out_payload_o = pay_q;
  assign out_status_o  = stat_q;

endmodule
